### sv/tchfe_pkg.sv
// ----------------------------------------------------------------------------
// tchfe_pkg
// Shared types and constants for the ClientHello field extractor.
// ----------------------------------------------------------------------------
package tchfe_pkg;

  localparam logic [15:0] EXT_SNI    = 16'h0000;
  localparam logic [15:0] EXT_ALPN   = 16'h0010;
  localparam logic [15:0] EXT_SIGALG = 16'h000d;
  localparam logic [15:0] EXT_VERS   = 16'h002b;
  localparam logic [15:0] RANDOM_LEN = 16'd32;
  localparam logic [7:0]  ASCII_ZERO = 8'd48;

  localparam logic [2:0] KIND_CIPHER = 3'd0;
  localparam logic [2:0] KIND_EXT    = 3'd1;
  localparam logic [2:0] KIND_SIGALG = 3'd2;
  localparam logic [2:0] KIND_OK     = 3'd3;
  localparam logic [2:0] KIND_BAD    = 3'd4;

  // One result record.
  typedef struct packed {
    logic        end_of_message;
    logic [13:0] extension_total;
    logic [14:0] cipher_total;
    logic [7:0]  alpn_last_char;
    logic [7:0]  alpn_first_char;
    logic        alpn_present;
    logic        sni_present;
    logic        quic_flag;
    logic [15:0] top_version;
    logic        in_hash_list;
    logic [15:0] code;
    logic [2:0]  kind;
  } rec_t;

  // Up to two records caused by one byte.
  typedef struct packed {
    logic  v0;
    logic  v1;
    rec_t  r0;
    rec_t  r1;
  } recs_t;

  function automatic logic is_grease(input logic [15:0] v);
    return (v[11:8] == 4'ha) && (v[15:8] == v[7:0]);
  endfunction

endpackage

### sv/tchfe_parser.sv
// ----------------------------------------------------------------------------
// tchfe_parser
// Byte-wise ClientHello parse state; registered input byte in, records out.
// ----------------------------------------------------------------------------
module tchfe_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          b,
  input  logic                quic,
  input  logic                fin,
  output tchfe_pkg::recs_t    recs
);

  typedef enum logic [3:0] {
    PH_LEG_HI, PH_LEG_LO, PH_RANDOM, PH_SID_LEN, PH_SID_BODY, PH_CS_HI,
    PH_CS_LO, PH_CS_BODY, PH_CM_LEN, PH_CM_BODY, PH_EX_HI, PH_EX_LO,
    PH_EX_HDR, PH_EX_BODY, PH_DONE, PH_BAD
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [15:0] fr_r, fr_nxt, ebr_r, ebr_nxt, typ_r, typ_nxt, len_r, len_nxt;
  logic [15:0] off_r, off_nxt, best_r, best_nxt, leg_r, leg_nxt;
  logic [7:0]  held_r, held_nxt, aln_r, aln_nxt, af_r, af_nxt, al_r, al_nxt;
  logic        sv_r, sv_nxt, av_r, av_nxt, sni_r, sni_nxt, ve_r, ve_nxt;
  logic [14:0] cc_r, cc_nxt;
  logic [13:0] ec_r, ec_nxt;
  logic [15:0] word, o1;
  logic [16:0] pair2, b3, fr2, aend;
  tchfe_pkg::rec_t r0, r1, sm;
  logic v0;

  assign word  = {held_r, b};
  assign pair2 = {1'b0, word} + 17'd2;
  assign b3    = {9'd0, b} + 17'd3;
  assign fr2   = {1'b0, fr_r} + 17'd2;
  assign aend  = 17'd2 + {9'd0, aln_r};

  always_comb begin
    ph_nxt = ph_r; fr_nxt = fr_r; ebr_nxt = ebr_r; typ_nxt = typ_r;
    len_nxt = len_r; off_nxt = off_r; best_nxt = best_r; leg_nxt = leg_r;
    held_nxt = held_r; aln_nxt = aln_r; af_nxt = af_r; al_nxt = al_r;
    sv_nxt = sv_r; av_nxt = av_r; sni_nxt = sni_r; ve_nxt = ve_r;
    cc_nxt = cc_r; ec_nxt = ec_r; o1 = off_r + 16'd1;
    r0 = '0; v0 = 1'b0;
    case (ph_r)
      PH_LEG_HI: begin held_nxt = b; ph_nxt = PH_LEG_LO; end
      PH_LEG_LO: begin leg_nxt = word; fr_nxt = tchfe_pkg::RANDOM_LEN; ph_nxt = PH_RANDOM; end
      PH_RANDOM, PH_SID_BODY, PH_CM_BODY: begin
        fr_nxt = fr_r - 16'd1;
        if (fr_r == 16'd1) begin
          ph_nxt = (ph_r == PH_RANDOM) ? PH_SID_LEN :
                   (ph_r == PH_SID_BODY) ? PH_CS_HI : PH_EX_HI;
        end
      end
      PH_SID_LEN: begin
        fr_nxt = {8'd0, b}; ph_nxt = (b != 8'd0) ? PH_SID_BODY : PH_CS_HI;
      end
      PH_CM_LEN: begin
        fr_nxt = {8'd0, b}; ph_nxt = (b != 8'd0) ? PH_CM_BODY : PH_EX_HI;
      end
      PH_CS_HI, PH_EX_HI: begin
        held_nxt = b; ph_nxt = (ph_r == PH_CS_HI) ? PH_CS_LO : PH_EX_LO;
      end
      PH_CS_LO: begin
        fr_nxt = word;
        if (word[0]) ph_nxt = PH_BAD;
        else ph_nxt = (word != 16'd0) ? PH_CS_BODY : PH_CM_LEN;
      end
      PH_CS_BODY: begin
        if (!fr_r[0]) held_nxt = b;
        else if (!tchfe_pkg::is_grease(word)) begin
          cc_nxt = cc_r + 15'd1;
          r0.kind = tchfe_pkg::KIND_CIPHER; r0.code = word; v0 = 1'b1;
        end
        fr_nxt = fr_r - 16'd1;
        if (fr_r == 16'd1) ph_nxt = PH_CM_LEN;
      end
      PH_EX_LO: begin
        ebr_nxt = word;
        if (word >= 16'd4) begin ph_nxt = PH_EX_HDR; off_nxt = '0; end
        else ph_nxt = PH_DONE;
      end
      PH_EX_HDR: begin
        if (off_r == 16'd1) typ_nxt = word;
        if (off_r == 16'd3) len_nxt = word;
        held_nxt = b;
        ebr_nxt = ebr_r - 16'd1;
        off_nxt = o1;
        if (o1 == 16'd4) begin
          off_nxt = '0;
          if (len_nxt > ebr_nxt) ph_nxt = PH_BAD;
          else begin
            if (!tchfe_pkg::is_grease(typ_r)) begin
              ec_nxt = ec_r + 14'd1;
              if (typ_r == tchfe_pkg::EXT_SNI) sni_nxt = 1'b1;
              r0.kind = tchfe_pkg::KIND_EXT; r0.code = typ_r; v0 = 1'b1;
              r0.in_hash_list = (typ_r != tchfe_pkg::EXT_SNI) &&
                                (typ_r != tchfe_pkg::EXT_ALPN);
            end
            if (len_nxt == 16'd0) begin
              if (ebr_nxt >= 16'd4) ph_nxt = PH_EX_HDR;
              else ph_nxt = PH_DONE;
            end else ph_nxt = PH_EX_BODY;
          end
        end
      end
      PH_EX_BODY: begin
        if (typ_r == tchfe_pkg::EXT_ALPN) begin
          if (off_r == 16'd2) begin
            if (b != 8'd0 && b3 <= {1'b0, len_r}) begin
              aln_nxt = b; av_nxt = 1'b1;
            end else aln_nxt = '0;
          end
          if (aln_r != 8'd0 && off_r == 16'd3) af_nxt = b;
          if (aln_r != 8'd0 && {1'b0, off_r} == aend) al_nxt = b;
        end else if (typ_r == tchfe_pkg::EXT_SIGALG) begin
          if (off_r == 16'd1) begin
            sv_nxt = (pair2 <= {1'b0, len_r}) && !word[0];
            fr_nxt = word;
          end else if (off_r >= 16'd2 && off_r[0] && sv_r && {1'b0, off_r} < fr2) begin
            if (!tchfe_pkg::is_grease(word)) begin
              r0.kind = tchfe_pkg::KIND_SIGALG; r0.code = word; v0 = 1'b1;
            end
          end
        end else if (typ_r == tchfe_pkg::EXT_VERS) begin
          if (off_r == 16'd0) ve_nxt = 1'b1;
          if (off_r >= 16'd2 && !off_r[0] && !tchfe_pkg::is_grease(word) && word > best_r)
            best_nxt = word;
        end
        held_nxt = b;
        off_nxt = o1;
        ebr_nxt = ebr_r - 16'd1;
        if (o1 >= len_r) begin
          if (ebr_nxt >= 16'd4) begin ph_nxt = PH_EX_HDR; off_nxt = '0; end
          else ph_nxt = PH_DONE;
        end
      end
      PH_DONE: if (ebr_r != 16'd0) ebr_nxt = ebr_r - 16'd1;
      default: ;
    endcase
  end

  always_comb begin
    sm = '0;
    sm.end_of_message = 1'b1;
    if (ph_nxt == PH_DONE && ebr_nxt == 16'd0) begin
      sm.kind = tchfe_pkg::KIND_OK;
      sm.top_version = (ve_nxt && best_nxt != 16'd0) ? best_nxt : leg_nxt;
      sm.quic_flag = quic;
      sm.sni_present = sni_nxt;
      sm.alpn_present = av_nxt;
      sm.alpn_first_char = af_nxt;
      sm.alpn_last_char = al_nxt;
      sm.cipher_total = cc_nxt;
      sm.extension_total = ec_nxt;
    end else sm.kind = tchfe_pkg::KIND_BAD;
    r1 = sm;
    recs.v0 = v0 | fin;
    recs.v1 = v0 & fin;
    recs.r0 = v0 ? r0 : sm;
    recs.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && fin)) begin
      ph_r <= PH_LEG_HI; fr_r <= '0; ebr_r <= '0; held_r <= '0; typ_r <= '0;
      len_r <= '0; off_r <= '0; sv_r <= 1'b0; aln_r <= '0;
      af_r <= tchfe_pkg::ASCII_ZERO; al_r <= tchfe_pkg::ASCII_ZERO;
      av_r <= 1'b0; sni_r <= 1'b0; ve_r <= 1'b0; best_r <= '0; leg_r <= '0;
      cc_r <= '0; ec_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt; fr_r <= fr_nxt; ebr_r <= ebr_nxt; held_r <= held_nxt;
      typ_r <= typ_nxt; len_r <= len_nxt; off_r <= off_nxt; sv_r <= sv_nxt;
      aln_r <= aln_nxt; af_r <= af_nxt; al_r <= al_nxt; av_r <= av_nxt;
      sni_r <= sni_nxt; ve_r <= ve_nxt; best_r <= best_nxt; leg_r <= leg_nxt;
      cc_r <= cc_nxt; ec_r <= ec_nxt;
    end
  end

endmodule

### sv/tchfe_out_queue.sv
// ----------------------------------------------------------------------------
// tchfe_out_queue
// Four-entry result queue; takes up to two records a cycle, gives one when out_ready is high.
// ----------------------------------------------------------------------------
module tchfe_out_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  tchfe_pkg::recs_t             recs,
  output logic                         room,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tchfe_pkg::rec_t              out_rec
);

  tchfe_pkg::rec_t mem_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r, cnt_nxt, fill;
  logic       pop, p0, p1;

  assign out_valid = cnt_r != 3'd0;
  assign pop  = out_valid && out_ready;
  assign p0   = push && recs.v0;
  assign p1   = push && recs.v1;
  // count the records landing this cycle: a new byte may add two more
  assign fill = cnt_r + {2'd0, p0} + {2'd0, p1};
  assign room = fill <= 3'd2;
  assign out_rec = mem_r[rd_r];
  assign cnt_nxt = fill - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (pop) rd_r <= rd_r + 2'd1;
      wr_r <= wr_r + {1'b0, p0} + {1'b0, p1};
      cnt_r <= cnt_nxt;
    end
    if (p0) mem_r[wr_r] <= recs.r0;
    if (p1) mem_r[wr_r + 2'd1] <= recs.r1;
  end

endmodule

### sv/tls_client_hello_field_extractor_core.sv
// ----------------------------------------------------------------------------
// tls_client_hello_field_extractor_core
// Streams a ClientHello body and emits cipher, extension and sigalg records.
// ----------------------------------------------------------------------------
// Input channel in_*: one body byte per word, in_tlast on the final byte.
// Output channel out_*: one record per word; out_tuser holds the kind and
// out_tlast marks the summary.
// A byte is registered on accept and parsed in the next cycle, when its
// records enter a four-entry queue; they reach out_* from there, behind any
// records already queued. One byte is taken every cycle while the queue,
// counting the records of the byte being parsed, holds two or fewer records;
// a final byte with a record of its own adds two.
// Throughput: one byte per cycle, limited by the one-record-per-cycle
// output port when records are dense.
// Reset clears the parse state and empties the queue; the summary word also
// returns the parser to its reset state for the next message.
// When the receiver stalls, records wait in the queue and in_tready drops
// once the queue can no longer take two more records.
// ----------------------------------------------------------------------------
module tls_client_hello_field_extractor_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // is_quic
  input  logic         in_tlast,   // final_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // code[15:0], in_hash_list[16], top_version[32:17], quic_flag[33],
  // sni_present[34], alpn_present[35], alpn_first_char[43:36],
  // alpn_last_char[51:44], cipher_total[66:52], extension_total[80:67], pad
  output logic [87:0]  out_tdata,
  output logic [2:0]   out_tuser,  // kind
  output logic         out_tlast   // end_of_message
);

  logic       v_r;
  logic [7:0] b_r;
  logic       q_r, f_r, room;
  tchfe_pkg::recs_t recs;
  tchfe_pkg::rec_t  rec;

  assign in_tready = room;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= in_tvalid && in_tready;
    if (in_tvalid && in_tready) begin
      b_r <= in_tdata; q_r <= in_tuser; f_r <= in_tlast;
    end
  end

  tchfe_parser u_parser (
    .clk(clk), .rst_n(rst_n), .step(v_r), .b(b_r), .quic(q_r), .fin(f_r),
    .recs(recs)
  );

  // room counts the records of the byte being parsed
  tchfe_out_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(v_r), .recs(recs), .room(room),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_rec(rec)
  );

  assign out_tdata = {7'd0, rec.extension_total, rec.cipher_total, rec.alpn_last_char,
                      rec.alpn_first_char, rec.alpn_present, rec.sni_present,
                      rec.quic_flag, rec.top_version, rec.in_hash_list, rec.code};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.end_of_message;

endmodule

### sv/tchfe_checker.sv
// ----------------------------------------------------------------------------
// tchfe_checker
// Port-level checks for the ClientHello field extractor.
// ----------------------------------------------------------------------------
module tchfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled word changed");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (out_tuser == tchfe_pkg::KIND_OK ||
                                 out_tuser == tchfe_pkg::KIND_BAD))
    else $error("tlast disagrees with kind");
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tchfe_pkg::KIND_BAD |-> out_tdata[80:0] == '0)
    else $error("malformed summary carries data");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:81] == '0)
    else $error("pad bits set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind tls_client_hello_field_extractor_core tchfe_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
